// ===== src/mros_pkg.sv =====
// ----------------------------------------------------------------------------
// mros_pkg
// Shared types, constants and character helpers of the markup reveal offset
// scanner.
// ----------------------------------------------------------------------------
package mros_pkg;

  localparam int MaxText = 64;
  localparam int AddrW   = $clog2(MaxText);
  localparam int LenW    = $clog2(MaxText + 1);
  localparam int UnitW   = 16;

  localparam logic [UnitW-1:0] ChLt    = 16'h003C;
  localparam logic [UnitW-1:0] ChGt    = 16'h003E;
  localparam logic [UnitW-1:0] ChSlash = 16'h002F;
  localparam logic [UnitW-1:0] ChAmp   = 16'h0026;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_FETCH,
    CMD_READ,
    CMD_ESC_BEGIN,
    CMD_ESC_STEP,
    CMD_TAG_STEP,
    CMD_TAG_CLOSE,
    CMD_EMIT_ONE,
    CMD_EMIT_NOGT,
    CMD_EMIT_PTR,
    CMD_FINISH
  } cmd_e;

  typedef enum logic [1:0] {
    ESC_QUOT,
    ESC_LT,
    ESC_GT,
    ESC_AMP
  } esc_e;

  typedef struct packed {
    logic pos_end;
    logic more;
    logic is_lt;
    logic is_amp;
    logic is_hs;
    logic is_ls;
    logic is_gt;
    logic nogt;
    logic esc_kind_ok;
    logic esc_match;
    logic esc_last;
  } status_t;

  function automatic logic is_space(input logic [UnitW-1:0] u);
    logic r;
    r = 1'b0;
    if (u inside {[16'h0009:16'h000D], [16'h2000:16'h200A], 16'h0020, 16'h0085,
                  16'h00A0, 16'h1680, 16'h2028, 16'h2029, 16'h202F, 16'h205F,
                  16'h3000}) begin
      r = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [UnitW-1:0] esc_char(input esc_e kind, input logic [2:0] k);
    logic [UnitW-1:0] c;
    c = 16'h0000;
    case (kind)
      ESC_QUOT: begin
        case (k)
          3'd2: c = 16'h0075;
          3'd3: c = 16'h006F;
          3'd4: c = 16'h0074;
          3'd5: c = 16'h003B;
          default: c = 16'h0000;
        endcase
      end
      ESC_LT, ESC_GT: begin
        case (k)
          3'd2: c = 16'h0074;
          3'd3: c = 16'h003B;
          default: c = 16'h0000;
        endcase
      end
      ESC_AMP: begin
        case (k)
          3'd2: c = 16'h006D;
          3'd3: c = 16'h0070;
          3'd4: c = 16'h003B;
          default: c = 16'h0000;
        endcase
      end
      default: c = 16'h0000;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] esc_last_idx(input esc_e kind);
    logic [2:0] r;
    case (kind)
      ESC_QUOT: r = 3'd5;
      ESC_AMP:  r = 3'd4;
      default:  r = 3'd3;
    endcase
    return r;
  endfunction

endpackage

// ===== src/mros_dp.sv =====
// ----------------------------------------------------------------------------
// mros_dp
// Text store, scan pointers, nesting depth and result registers.
// ----------------------------------------------------------------------------
module mros_dp (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mros_pkg::cmd_e           cmd_i,
  input  logic [15:0]              code_unit_i,
  output mros_pkg::status_t        status_o,
  output logic                     result_strobe_o,
  output logic [6:0]               end_offset_o,
  output logic [6:0]               open_depth_o,
  output logic                     last_result_o,
  output logic                     no_character_o,
  output logic                     truncated_o
);
  import mros_pkg::*;

  logic [UnitW-1:0] mem [MaxText];
  logic [UnitW-1:0] rdata_q;
  logic [AddrW-1:0] raddr;

  logic [LenW-1:0] len_q, pos_q, ptr_q, depth_q, pend_off_q, pend_dep_q, emit_off;
  logic            ovf_q, nogt_q, pend_v_q;
  logic            first_q, closing_q, slash_q;
  esc_e            kind_q;
  logic [2:0]      kidx_q;
  logic            emit;

  logic            strobe_q, last_q, nochar_q, trunc_q;
  logic [LenW-1:0] off_q, dep_q;

  assign raddr = (cmd_i == CMD_FETCH) ? pos_q[AddrW-1:0] : ptr_q[AddrW-1:0];
  assign emit  = (cmd_i == CMD_EMIT_ONE) || (cmd_i == CMD_EMIT_NOGT) ||
                 (cmd_i == CMD_EMIT_PTR);
  assign emit_off = (cmd_i == CMD_EMIT_PTR) ? ptr_q : pos_q + LenW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_LOAD && len_q != LenW'(MaxText)) begin
      mem[len_q[AddrW-1:0]] <= code_unit_i;
    end
    rdata_q <= mem[raddr];
  end

  always_comb begin
    status_o.pos_end     = (pos_q == len_q);
    status_o.more        = (ptr_q < len_q);
    status_o.is_lt       = (rdata_q == ChLt);
    status_o.is_amp      = (rdata_q == ChAmp);
    status_o.is_hs       = (rdata_q inside {[16'hD800:16'hDBFF]});
    status_o.is_ls       = (rdata_q inside {[16'hDC00:16'hDFFF]});
    status_o.is_gt       = (rdata_q == ChGt);
    status_o.nogt        = nogt_q;
    status_o.esc_kind_ok = (rdata_q inside {16'h0071, 16'h006C, 16'h0067, 16'h0061});
    status_o.esc_match   = (rdata_q == esc_char(kind_q, kidx_q));
    status_o.esc_last    = (kidx_q == esc_last_idx(kind_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      ovf_q    <= 1'b0;
      pos_q    <= '0;
      ptr_q    <= '0;
      depth_q  <= '0;
      nogt_q   <= 1'b0;
      pend_v_q <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= 1'b0;
      case (cmd_i)
        CMD_LOAD: begin
          if (len_q != LenW'(MaxText)) len_q <= len_q + LenW'(1);
          else ovf_q <= 1'b1;
        end
        CMD_FETCH: ptr_q <= pos_q + LenW'(1);
        CMD_READ, CMD_ESC_BEGIN, CMD_ESC_STEP, CMD_TAG_STEP: ptr_q <= ptr_q + LenW'(1);
        CMD_TAG_CLOSE: begin
          pos_q <= ptr_q;
          if (closing_q) begin
            if (depth_q != '0) depth_q <= depth_q - LenW'(1);
          end else if (!slash_q) begin
            depth_q <= depth_q + LenW'(1);
          end
        end
        CMD_FINISH: begin
          strobe_q <= 1'b1;
          len_q    <= '0;
          ovf_q    <= 1'b0;
          pos_q    <= '0;
          depth_q  <= '0;
          nogt_q   <= 1'b0;
          pend_v_q <= 1'b0;
        end
        default: ;
      endcase
      if (emit) begin
        pos_q    <= emit_off;
        pend_v_q <= 1'b1;
        strobe_q <= pend_v_q;
        if (cmd_i == CMD_EMIT_NOGT) nogt_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_READ) begin
      first_q   <= 1'b1;
      closing_q <= 1'b0;
      slash_q   <= 1'b0;
    end
    if (cmd_i == CMD_TAG_STEP) begin
      first_q <= 1'b0;
      if (first_q && rdata_q == ChSlash) closing_q <= 1'b1;
      if (!is_space(rdata_q)) slash_q <= (rdata_q == ChSlash);
    end
    if (cmd_i == CMD_ESC_BEGIN) begin
      case (rdata_q)
        16'h0071: kind_q <= ESC_QUOT;
        16'h006C: kind_q <= ESC_LT;
        16'h0067: kind_q <= ESC_GT;
        default:  kind_q <= ESC_AMP;
      endcase
      kidx_q <= 3'd2;
    end
    if (cmd_i == CMD_ESC_STEP) kidx_q <= kidx_q + 3'd1;
    if (emit) begin
      pend_off_q <= emit_off;
      pend_dep_q <= depth_q;
      off_q      <= pend_off_q;
      dep_q      <= pend_dep_q;
      last_q     <= 1'b0;
      nochar_q   <= 1'b0;
      trunc_q    <= ovf_q;
    end
    if (cmd_i == CMD_FINISH) begin
      off_q    <= pend_v_q ? pend_off_q : '0;
      dep_q    <= pend_v_q ? pend_dep_q : '0;
      last_q   <= 1'b1;
      nochar_q <= !pend_v_q;
      trunc_q  <= ovf_q;
    end
  end

  assign result_strobe_o = strobe_q;
  assign end_offset_o    = off_q;
  assign open_depth_o    = dep_q;
  assign last_result_o   = last_q;
  assign no_character_o  = nochar_q;
  assign truncated_o     = trunc_q;

endmodule

// ===== src/mros_ctrl.sv =====
// ----------------------------------------------------------------------------
// mros_ctrl
// Sequencer for loading and scanning one text.
// ----------------------------------------------------------------------------
module mros_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              last_unit_i,
  input  mros_pkg::status_t status_i,
  output mros_pkg::cmd_e    cmd_o,
  output logic              busy_o
);
  import mros_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FETCH  = 3'd1;
  localparam logic [2:0] S_CLASS  = 3'd2;
  localparam logic [2:0] S_TAG    = 3'd3;
  localparam logic [2:0] S_ESC1   = 3'd4;
  localparam logic [2:0] S_ESC    = 3'd5;
  localparam logic [2:0] S_SUR    = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o = CMD_LOAD;
          if (last_unit_i) state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        if (status_i.pos_end) begin
          state_d = S_FINISH;
        end else begin
          cmd_o   = CMD_FETCH;
          state_d = S_CLASS;
        end
      end
      S_CLASS: begin
        state_d = S_FETCH;
        if (status_i.is_lt && !status_i.nogt) begin
          if (status_i.more) begin
            cmd_o   = CMD_READ;
            state_d = S_TAG;
          end else begin
            cmd_o = CMD_EMIT_NOGT;
          end
        end else if (status_i.is_amp && status_i.more) begin
          cmd_o   = CMD_READ;
          state_d = S_ESC1;
        end else if (status_i.is_hs && status_i.more) begin
          cmd_o   = CMD_READ;
          state_d = S_SUR;
        end else begin
          cmd_o = CMD_EMIT_ONE;
        end
      end
      S_TAG: begin
        if (status_i.is_gt) begin
          cmd_o   = CMD_TAG_CLOSE;
          state_d = S_FETCH;
        end else if (status_i.more) begin
          cmd_o = CMD_TAG_STEP;
        end else begin
          cmd_o   = CMD_EMIT_NOGT;
          state_d = S_FETCH;
        end
      end
      S_ESC1: begin
        if (status_i.esc_kind_ok && status_i.more) begin
          cmd_o   = CMD_ESC_BEGIN;
          state_d = S_ESC;
        end else begin
          cmd_o   = CMD_EMIT_ONE;
          state_d = S_FETCH;
        end
      end
      S_ESC: begin
        if (status_i.esc_match && status_i.esc_last) begin
          cmd_o   = CMD_EMIT_PTR;
          state_d = S_FETCH;
        end else if (status_i.esc_match && status_i.more) begin
          cmd_o = CMD_ESC_STEP;
        end else begin
          cmd_o   = CMD_EMIT_ONE;
          state_d = S_FETCH;
        end
      end
      S_SUR: begin
        cmd_o   = status_i.is_ls ? CMD_EMIT_PTR : CMD_EMIT_ONE;
        state_d = S_FETCH;
      end
      S_FINISH: begin
        cmd_o   = CMD_FINISH;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== src/markup_reveal_offset_scanner.sv =====
// Loading takes one code unit per cycle while start is high; busy stays low
// until the final unit. Scanning then walks the single-port text store: a
// plain character is fetched, then classified; a tag, escape or pair reads
// each further unit in turn. A result transfers in the cycle after the next
// character is found; the last follows the finish state, when a new text may
// already load. The receiver cannot stall. Reset clears control.
// ----------------------------------------------------------------------------
// markup_reveal_offset_scanner
// Top level: reveal offsets and tag depth of visible characters in a text.
// ----------------------------------------------------------------------------
module markup_reveal_offset_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] code_unit_i,
  input  logic        last_unit_i,
  output logic        result_strobe_o,
  output logic [6:0]  end_offset_o,
  output logic [6:0]  open_depth_o,
  output logic        last_result_o,
  output logic        no_character_o,
  output logic        truncated_o
);
  import mros_pkg::*;

  cmd_e    cmd;
  status_t status;

  mros_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .last_unit_i (last_unit_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .busy_o      (busy_o)
  );

  mros_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .code_unit_i     (code_unit_i),
    .status_o        (status),
    .result_strobe_o (result_strobe_o),
    .end_offset_o    (end_offset_o),
    .open_depth_o    (open_depth_o),
    .last_result_o   (last_result_o),
    .no_character_o  (no_character_o),
    .truncated_o     (truncated_o)
  );

  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(busy_o))
    else $error("result without scan");

  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && no_character_o) |->
      (last_result_o && end_offset_o == '0 && open_depth_o == '0))
    else $error("bad empty marker");

  a_offset_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> (end_offset_o <= 7'(MaxText)))
    else $error("offset out of range");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && last_result_o) |-> !busy_o)
    else $error("busy after last result");

endmodule
